[src/telnet_receive_command_filter_unit_assert.svh]
// assertion macros for the telnet receive filter
`ifndef TELNET_RECEIVE_COMMAND_FILTER_UNIT_ASSERT_SVH
`define TELNET_RECEIVE_COMMAND_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TRCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TRCF_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRCF_ASSERT(lbl, prop, msg)
`define TRCF_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

[src/trcf_pkg.sv]
`timescale 1ns / 1ps

package trcf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // telnet command bytes
  localparam logic [BYTE_W-1:0] TN_IAC  = 8'hFF;
  localparam logic [BYTE_W-1:0] TN_WILL = 8'hFB;
  localparam logic [BYTE_W-1:0] TN_DONT = 8'hFE;
  localparam logic [BYTE_W-1:0] TN_SB   = 8'hFA;
  localparam logic [BYTE_W-1:0] TN_SE   = 8'hF0;

  // command phase codes
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CMD    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_OPT    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SB     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SB_IAC = 3'd4;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // register map, word index
  localparam logic REG_IDLE_LIMIT = 1'b0;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              link_connected;
  } item_t;

  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              closed;
    logic              became_closed;
  } result_t;

endpackage

[src/telnet_receive_command_filter_unit.sv]
`timescale 1ns / 1ps

// telnet receive filter: each input beat is a received byte or an empty poll, and each
// one yields exactly one output beat; telnet commands (IAC sequences, option negotiation,
// subnegotiation up to IAC SE) are stripped and only payload bytes come out with
// data_valid set, IAC IAC coming out as a literal 0xFF; consecutive empty polls are
// counted and when the count reaches idle_check_limit (APB register at offset 0, reset
// 1000) the sampled link_connected is checked; if the link is down the filter closes for
// good, flags became_closed on that one beat and afterwards returns closed beats only
// until reset; throughput is one beat per clock while the consumer keeps out_ready high;
// each beat passes the input register and then the result register, the input register
// feeding the result register through the update of command phase, idle count and
// closed flag; a stalled consumer holds the result register and the input register
// behind it, and new beats wait only once both are full

module telnet_receive_command_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [trcf_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          link_connected,
  // output beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          data_valid,
  output logic [trcf_pkg::BYTE_W-1:0]   data_byte,
  output logic                          closed,
  output logic                          became_closed,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [trcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [trcf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  trcf_pkg::item_t              in_item;
  trcf_pkg::item_t              item;
  trcf_pkg::result_t            res_next;
  trcf_pkg::result_t            res;
  logic                         item_valid;
  logic                         take;
  logic [trcf_pkg::LIMIT_W-1:0] idle_check_limit;

  // pack the input beat
  assign in_item.req_type       = req_type;
  assign in_item.rx_byte        = rx_byte;
  assign in_item.link_connected = link_connected;

  // register file, only idle_check_limit lives here
  trcf_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .idle_check_limit (idle_check_limit)
  );

  // input register, takes a new beat whenever the held one moves on
  trcf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // filter state: command phase, idle poll count, closed flag
  trcf_core u_core (
    .clk              (clk),
    .rst              (rst),
    .idle_check_limit (idle_check_limit),
    .adv              (take),
    .item             (item),
    .res_next         (res_next)
  );

  // result register, decouples the consumer from the filter
  trcf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res_next   (res_next),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  // unpack the output beat
  assign data_valid    = res.data_valid;
  assign data_byte     = res.data_byte;
  assign closed        = res.closed;
  assign became_closed = res.became_closed;

endmodule

[src/trcf_regs.sv]
`timescale 1ns / 1ps

module trcf_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [trcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [trcf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [trcf_pkg::LIMIT_W-1:0]  idle_check_limit
);

  logic word_idx;
  logic wr_en;

  assign word_idx = paddr[2];
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && (word_idx == trcf_pkg::REG_IDLE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_check_limit <= trcf_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      idle_check_limit <= pwdata[trcf_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (word_idx == trcf_pkg::REG_IDLE_LIMIT) begin
      prdata = {{(trcf_pkg::PDATA_W - trcf_pkg::LIMIT_W){1'b0}}, idle_check_limit};
    end
  end

endmodule

[src/trcf_in_stage.sv]
`timescale 1ns / 1ps

module trcf_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  trcf_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output trcf_pkg::item_t item
);

  logic            valid_q;
  trcf_pkg::item_t item_q;

  // free slot, or the held beat moves on this cycle
  assign in_ready   = !valid_q || take;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

endmodule

[src/trcf_core.sv]
`timescale 1ns / 1ps
`include "telnet_receive_command_filter_unit_assert.svh"

module trcf_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [trcf_pkg::LIMIT_W-1:0] idle_check_limit,
  input  logic                         adv,
  input  trcf_pkg::item_t              item,
  output trcf_pkg::result_t            res_next
);

  logic [trcf_pkg::PHASE_W-1:0] phase;
  logic [trcf_pkg::PHASE_W-1:0] phase_next;
  logic [trcf_pkg::LIMIT_W-1:0] idle_polls;
  logic [trcf_pkg::LIMIT_W-1:0] idle_polls_next;
  logic [trcf_pkg::LIMIT_W-1:0] idle_inc;
  logic                         link_closed;
  logic                         link_closed_next;
  logic                         pass;
  logic [trcf_pkg::BYTE_W-1:0]  b;

  assign b        = item.rx_byte;
  assign idle_inc = idle_polls + 1'b1;

  always_comb begin
    phase_next       = phase;
    idle_polls_next  = idle_polls;
    link_closed_next = link_closed;
    pass             = 1'b0;
    res_next.became_closed = 1'b0;
    if (!link_closed) begin
      if (item.req_type == trcf_pkg::REQ_BYTE) begin
        idle_polls_next = '0;
        case (phase)
          trcf_pkg::PH_DATA: begin
            if (b == trcf_pkg::TN_IAC) begin
              phase_next = trcf_pkg::PH_CMD;
            end else begin
              pass = 1'b1;
            end
          end
          trcf_pkg::PH_CMD: begin
            if (b == trcf_pkg::TN_IAC) begin
              phase_next = trcf_pkg::PH_DATA;
              pass       = 1'b1;
            end else if (b inside {[trcf_pkg::TN_WILL:trcf_pkg::TN_DONT]}) begin
              phase_next = trcf_pkg::PH_OPT;
            end else if (b == trcf_pkg::TN_SB) begin
              phase_next = trcf_pkg::PH_SB;
            end else begin
              phase_next = trcf_pkg::PH_DATA;
            end
          end
          trcf_pkg::PH_OPT: begin
            phase_next = trcf_pkg::PH_DATA;
          end
          trcf_pkg::PH_SB: begin
            if (b == trcf_pkg::TN_IAC) begin
              phase_next = trcf_pkg::PH_SB_IAC;
            end
          end
          default: begin
            // after IAC inside a subnegotiation
            phase_next = (b == trcf_pkg::TN_SE) ? trcf_pkg::PH_DATA : trcf_pkg::PH_SB;
          end
        endcase
      end else begin
        idle_polls_next = idle_inc;
        if (idle_inc >= idle_check_limit) begin
          idle_polls_next = '0;
          if (!item.link_connected) begin
            link_closed_next       = 1'b1;
            res_next.became_closed = 1'b1;
          end
        end
      end
    end
    res_next.data_valid = pass;
    res_next.data_byte  = pass ? b : '0;
    res_next.closed     = link_closed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= trcf_pkg::PH_DATA;
      idle_polls  <= '0;
      link_closed <= 1'b0;
    end else if (adv) begin
      phase       <= phase_next;
      idle_polls  <= idle_polls_next;
      link_closed <= link_closed_next;
    end
  end

  `TRCF_ASSERT_NORST(a_reset_opens, rst |=> (!link_closed && phase == trcf_pkg::PH_DATA && idle_polls == '0), "reset did not clear filter state")
  `TRCF_ASSERT(a_closed_sticky, link_closed |=> link_closed, "closed state fell without reset")
  `TRCF_ASSERT(a_closed_silent, link_closed |-> (!res_next.data_valid && !res_next.became_closed), "closed filter produced data or pulse")
  `TRCF_ASSERT(a_byte_clears_idle, (adv && item.req_type == trcf_pkg::REQ_BYTE) |=> (idle_polls == '0), "byte did not clear idle count")
  `TRCF_ASSERT(a_pulse_closes, (adv && res_next.became_closed) |-> !link_closed ##1 link_closed, "close pulse without state change")

endmodule

[src/trcf_out_stage.sv]
`timescale 1ns / 1ps

module trcf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  trcf_pkg::result_t res_next,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output trcf_pkg::result_t res
);

  logic              valid_q;
  trcf_pkg::result_t res_q;
  logic              room;

  // result register empty or being drained this cycle
  assign room      = !valid_q || out_ready;
  assign take      = item_valid && room;
  assign out_valid = valid_q;
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (room) begin
      valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

endmodule
